>>> rtl/mlfs_pkg.sv
// Package for the multilevel feedback scheduler.
// Holds the field widths, the result and controller codes, and the quantum reset values.
// Depends on nothing.
package mlfs_pkg;

    // Field widths of the item and result channels.
    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int RLEVEL_W  = 2;
    localparam int ENTRY_W   = ID_W + TIME_W;

    // Configuration port.
    localparam int NUM_QUANTUM_REGS = 4;
    localparam int QIDX_W           = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    // Operation codes of the input item.
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED   = 3'd0,
        ST_REJECTED   = 3'd1,
        ST_IDLE_TICK  = 3'd2,
        ST_RAN        = 3'd3,
        ST_FINISHED   = 3'd4,
        ST_MOVED_DOWN = 3'd5
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ARRIVE,
        S_TICK
    } state_t;

    // Reset value of each quantum register.
    function automatic logic [TIME_W-1:0] quantum_reset(input logic [QIDX_W-1:0] idx);
        logic [TIME_W-1:0] val;
        case (idx)
            2'd0:    val = 16'd2;
            2'd1:    val = 16'd4;
            2'd2:    val = 16'd8;
            default: val = 16'd16;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/multilevel_feedback_scheduler_top.sv
// An accepted item is latched, then its result goes to the result register once that
// is free; one item is in work at a time. A tick reads the head entry from the task
// memory as it is accepted, then writes it back, moves it or, if it is done, drops it.
// The result register lets the next item be accepted while a result waits.
// Reset (aresetn, synchronous, active low) empties all levels, reloads the quantum
// registers and slice counters; the task memory is not cleared.
// Multilevel feedback scheduler: per-level FIFO queues held in one task memory.
// Depends on mlfs_pkg.
module multilevel_feedback_scheduler_top #(
    parameter int NUM_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [mlfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mlfs_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    // Input item channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [mlfs_pkg::ID_W-1:0]            s_task_id,
    input  logic [mlfs_pkg::TIME_W-1:0]          s_service_time,
    // Result item channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mlfs_pkg::STATUS_W-1:0]        m_status,
    output logic [mlfs_pkg::ID_W-1:0]            m_run_task_id,
    output logic [mlfs_pkg::RLEVEL_W-1:0]        m_run_level,
    output logic [mlfs_pkg::TIME_W-1:0]          m_remaining_after
);

    localparam int LVL_W    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W   = $clog2(MEM_DEPTH);
    localparam int TW       = mlfs_pkg::TIME_W;
    localparam int IW       = mlfs_pkg::ID_W;

    // Address of a slot within the task memory.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] pos);
        return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
    endfunction

    // Circular pointer advance.
    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] pos);
        return (pos == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pos + 1'b1;
    endfunction

    // Register index of a level: levels beyond the last register share it.
    function automatic logic [mlfs_pkg::QIDX_W-1:0] quantum_idx(input logic [LVL_W-1:0] lvl);
        logic [7:0] lvl8;
        lvl8 = 8'(lvl);
        return (lvl8 >= 8'(mlfs_pkg::NUM_QUANTUM_REGS - 1))
               ? mlfs_pkg::QIDX_W'(mlfs_pkg::NUM_QUANTUM_REGS - 1) : lvl8[1:0];
    endfunction

    // Control and state registers.
    mlfs_pkg::state_t                 state_reg, state_next;
    logic [TW-1:0]                    quantum_reg [mlfs_pkg::NUM_QUANTUM_REGS];
    logic [PTR_W-1:0]                 head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]                 head_next [NUM_LEVELS];
    logic [PTR_W-1:0]                 tail_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]                 tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]                 count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]                 count_next[NUM_LEVELS];
    logic [TW-1:0]                    slice_reg [NUM_LEVELS];
    logic [TW-1:0]                    slice_next[NUM_LEVELS];
    logic [CNT_W-1:0]                 held_reg, held_next;

    // Latched item and lookup result.
    logic [IW-1:0]                    id_reg, id_next;
    logic [TW-1:0]                    svc_reg, svc_next;
    logic [LVL_W-1:0]                 lvl_reg, lvl_next;
    logic                             found_reg, found_next;

    // Result register.
    logic                             m_valid_reg, m_valid_next;
    logic [mlfs_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [IW-1:0]                    rid_reg, rid_next;
    logic [mlfs_pkg::RLEVEL_W-1:0]    rlevel_reg, rlevel_next;
    logic [TW-1:0]                    remain_reg, remain_next;

    // Task memory and its ports.
    logic [mlfs_pkg::ENTRY_W-1:0]     task_mem [MEM_DEPTH];
    logic [mlfs_pkg::ENTRY_W-1:0]     rd_data_reg;
    logic                             rd_en;
    logic [ADDR_W-1:0]                rd_addr;
    logic                             wr_en;
    logic [ADDR_W-1:0]                wr_addr;
    logic [mlfs_pkg::ENTRY_W-1:0]     wr_data;

    // Lookup of the highest nonempty level.
    logic                             any_found;
    logic [LVL_W-1:0]                 top_lvl;

    // Working values of a tick.
    logic                             out_free;
    logic                             accept;
    logic [IW-1:0]                    run_id;
    logic [TW-1:0]                    run_rem;
    logic [TW-1:0]                    slice_old;
    logic                             expire;
    logic [TW-1:0]                    q_val;
    logic [LVL_W-1:0]                 dest;
    logic [7:0]                       lvl_wide;

    assign s_ready  = (state_reg == mlfs_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_run_task_id     = rid_reg;
    assign m_run_level       = rlevel_reg;
    assign m_remaining_after = remain_reg;

    // Priority search: lowest-numbered level holding a task.
    always_comb begin
        any_found = 1'b0;
        top_lvl   = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                any_found = 1'b1;
                top_lvl   = LVL_W'(i);
            end
        end
    end

    // The head entry of the chosen level is read as the tick is accepted.
    assign rd_en   = accept && (s_op == mlfs_pkg::OP_TICK);
    assign rd_addr = slot_addr(top_lvl, head_reg[top_lvl]);

    // Task memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            task_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= task_mem[rd_addr];
        end
    end

    // Decode of the head entry and the slice counter of the running level.
    always_comb begin
        run_id    = rd_data_reg[mlfs_pkg::ENTRY_W-1:TW];
        run_rem   = (rd_data_reg[TW-1:0] == '0) ? '0 : rd_data_reg[TW-1:0] - 1'b1;
        slice_old = slice_reg[lvl_reg];
        expire    = (slice_old <= TW'(1));
        q_val     = (quantum_reg[quantum_idx(lvl_reg)] == '0)
                    ? TW'(1) : quantum_reg[quantum_idx(lvl_reg)];
        dest      = (lvl_reg == LVL_W'(NUM_LEVELS - 1)) ? lvl_reg : lvl_reg + 1'b1;
        lvl_wide  = 8'(lvl_reg);
    end

    // Next state, queue bookkeeping, memory writes and result.
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        slice_next   = slice_reg;
        held_next    = held_reg;
        id_next      = id_reg;
        svc_next     = svc_reg;
        lvl_next     = lvl_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        rid_next     = rid_reg;
        rlevel_next  = rlevel_reg;
        remain_next  = remain_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        case (state_reg)
            mlfs_pkg::S_IDLE: begin
                if (accept) begin
                    id_next    = s_task_id;
                    svc_next   = s_service_time;
                    lvl_next   = top_lvl;
                    found_next = any_found;
                    state_next = (s_op == mlfs_pkg::OP_TICK)
                                 ? mlfs_pkg::S_TICK : mlfs_pkg::S_ARRIVE;
                end
            end

            mlfs_pkg::S_ARRIVE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    rid_next     = id_reg;
                    rlevel_next  = '0;
                    if (held_reg >= CNT_W'(QUEUE_DEPTH)) begin
                        status_next = mlfs_pkg::ST_REJECTED;
                        remain_next = '0;
                    end else begin
                        // Append to the tail of level 0.
                        wr_en         = 1'b1;
                        wr_addr       = slot_addr('0, tail_reg[0]);
                        wr_data       = {id_reg, svc_reg};
                        tail_next[0]  = next_pos(tail_reg[0]);
                        count_next[0] = count_reg[0] + 1'b1;
                        held_next     = held_reg + 1'b1;
                        status_next   = mlfs_pkg::ST_ACCEPTED;
                        remain_next   = svc_reg;
                    end
                    state_next = mlfs_pkg::S_IDLE;
                end
            end

            mlfs_pkg::S_TICK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (!found_reg) begin
                        status_next = mlfs_pkg::ST_IDLE_TICK;
                        rid_next    = '0;
                        rlevel_next = '0;
                        remain_next = '0;
                    end else begin
                        rid_next    = run_id;
                        rlevel_next = lvl_wide[mlfs_pkg::RLEVEL_W-1:0];
                        remain_next = run_rem;
                        slice_next[lvl_reg] = expire ? q_val : slice_old - 1'b1;
                        if (run_rem == '0) begin
                            // Task done: it leaves its level.
                            head_next[lvl_reg]  = next_pos(head_reg[lvl_reg]);
                            count_next[lvl_reg] = count_reg[lvl_reg] - 1'b1;
                            held_next           = held_reg - 1'b1;
                            status_next         = mlfs_pkg::ST_FINISHED;
                        end else if (expire) begin
                            // Slice used up: the task goes to the tail of the next level,
                            // or of its own level at the bottom.
                            head_next[lvl_reg]  = next_pos(head_reg[lvl_reg]);
                            count_next[lvl_reg] = count_reg[lvl_reg] - 1'b1;
                            wr_en            = 1'b1;
                            wr_addr          = slot_addr(dest, tail_reg[dest]);
                            wr_data          = {run_id, run_rem};
                            tail_next[dest]  = next_pos(tail_reg[dest]);
                            count_next[dest] = count_next[dest] + 1'b1;
                            status_next      = (dest != lvl_reg)
                                               ? mlfs_pkg::ST_MOVED_DOWN : mlfs_pkg::ST_RAN;
                        end else begin
                            // Task keeps the head; its remaining time is written back.
                            wr_en       = 1'b1;
                            wr_addr     = slot_addr(lvl_reg, head_reg[lvl_reg]);
                            wr_data     = {run_id, run_rem};
                            status_next = mlfs_pkg::ST_RAN;
                        end
                    end
                    state_next = mlfs_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = mlfs_pkg::S_IDLE;
            end
        endcase
    end

    // Controller state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlfs_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Queue pointers, counters, slice counters and quantum registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
                slice_reg[i] <= mlfs_pkg::quantum_reset(quantum_idx(LVL_W'(i)));
            end
            for (int j = 0; j < mlfs_pkg::NUM_QUANTUM_REGS; j++) begin
                quantum_reg[j] <= mlfs_pkg::quantum_reset(mlfs_pkg::QIDX_W'(j));
            end
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            slice_reg   <= slice_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en &&
                (cfg_index < mlfs_pkg::CFG_IDX_W'(mlfs_pkg::NUM_QUANTUM_REGS))) begin
                quantum_reg[cfg_index[mlfs_pkg::QIDX_W-1:0]] <= cfg_wr_data;
            end
        end
    end

    // Latched item and result payload.
    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        svc_reg    <= svc_next;
        lvl_reg    <= lvl_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rlevel_reg <= rlevel_next;
        remain_reg <= remain_next;
    end

endmodule

>>> test/multilevel_feedback_scheduler_top_test.sv
// Self-checking testbench for the multilevel feedback scheduler: bursts of arrivals and ticks
// are checked item by item against a behavioural scheduler model over several quantum settings.
// Depends on mlfs_pkg and multilevel_feedback_scheduler_top.
module multilevel_feedback_scheduler_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEVELS    = 4;
    localparam int QUEUE_DEPTH   = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_CFG_SLOTS = 1 << mlfs_pkg::CFG_IDX_W;
    localparam int NUM_QREGS     = mlfs_pkg::NUM_QUANTUM_REGS;
    localparam int ID_W          = mlfs_pkg::ID_W;
    localparam int TIME_W        = mlfs_pkg::TIME_W;

    localparam logic [TIME_W-1:0] QUANTUM_AT_RESET [NUM_QREGS] = '{16'd2, 16'd4, 16'd8,
                                                                   16'd16};

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remain;
    } task_entry_t;

    typedef struct {
        logic              op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] svc;
    } request_t;

    typedef struct packed {
        mlfs_pkg::status_t             status;
        logic [ID_W-1:0]               id;
        logic [mlfs_pkg::RLEVEL_W-1:0] level;
        logic [TIME_W-1:0]             remain;
    } outcome_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    // Block ports.
    logic                            aclk           = 1'b0;
    logic                            aresetn        = 1'b0;
    logic                            cfg_wr_en      = 1'b0;
    logic [mlfs_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [mlfs_pkg::CFG_DATA_W-1:0] cfg_wr_data    = '0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic                            s_op           = mlfs_pkg::OP_ARRIVE;
    logic [ID_W-1:0]                 s_task_id      = '0;
    logic [TIME_W-1:0]               s_service_time = '0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [mlfs_pkg::STATUS_W-1:0]   m_status;
    logic [ID_W-1:0]                 m_run_task_id;
    logic [mlfs_pkg::RLEVEL_W-1:0]   m_run_level;
    logic [TIME_W-1:0]               m_remaining_after;

    // Stimulus and expected outcomes.
    request_t request_queue [$];
    outcome_t outcome_queue [$];
    bit       hold_sender = 1'b0;
    int       n_errors    = 0;
    int       n_accepted  = 0;
    int       n_cycles    = 0;
    int       status_seen [8];

    // Sender and receiver pacing.
    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_ALWAYS;
    int       rx_left    = 0;
    outcome_t predicted;
    outcome_t want;
    request_t next_req;

    // Scheduler model state.
    logic [TIME_W-1:0] q_quantum   [NUM_QREGS];
    task_entry_t       lvl_entries [NUM_LEVELS][QUEUE_DEPTH];
    int                lvl_head    [NUM_LEVELS];
    int                lvl_tail    [NUM_LEVELS];
    int                lvl_count   [NUM_LEVELS];
    logic [TIME_W-1:0] lvl_slice   [NUM_LEVELS];
    int                held_tasks;

    multilevel_feedback_scheduler_top #(
        .NUM_LEVELS (NUM_LEVELS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_task_id        (s_task_id),
        .s_service_time   (s_service_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_run_task_id    (m_run_task_id),
        .m_run_level      (m_run_level),
        .m_remaining_after(m_remaining_after)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Slice length of a level; levels past the last register share it, and zero counts as one.
    function automatic logic [TIME_W-1:0] slice_length(int lvl);
        logic [TIME_W-1:0] q;
        q = q_quantum[(lvl < NUM_QREGS) ? lvl : NUM_QREGS - 1];
        return (q == '0) ? 16'd1 : q;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < NUM_QREGS; i++) q_quantum[i] = QUANTUM_AT_RESET[i];
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_head[i]  = 0;
            lvl_tail[i]  = 0;
            lvl_count[i] = 0;
            lvl_slice[i] = slice_length(i);
        end
        held_tasks = 0;
    endfunction

    function automatic void enqueue_task(int lvl, logic [ID_W-1:0] id, logic [TIME_W-1:0] rem);
        lvl_entries[lvl][lvl_tail[lvl]] = '{id: id, remain: rem};
        lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QUEUE_DEPTH;
        lvl_count[lvl]++;
    endfunction

    function automatic void dequeue_head(int lvl);
        lvl_head[lvl] = (lvl_head[lvl] + 1) % QUEUE_DEPTH;
        lvl_count[lvl]--;
    endfunction

    // Applies one item to the scheduler model and returns the outcome it should produce.
    function automatic outcome_t scheduler_step(logic op, logic [ID_W-1:0] id,
                                                logic [TIME_W-1:0] svc);
        outcome_t          r;
        task_entry_t       e;
        bit                found;
        int                lvl;
        int                dest;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] sl;
        r.status = mlfs_pkg::ST_IDLE_TICK;
        r.id     = '0;
        r.level  = '0;
        r.remain = '0;
        found    = 1'b0;
        lvl      = 0;
        if (op == mlfs_pkg::OP_ARRIVE) begin
            r.id = id;
            if (held_tasks >= QUEUE_DEPTH) begin
                r.status = mlfs_pkg::ST_REJECTED;
            end else begin
                enqueue_task(0, id, svc);
                held_tasks++;
                r.status = mlfs_pkg::ST_ACCEPTED;
                r.remain = svc;
            end
        end else begin
            // The highest nonempty level is the lowest-numbered one.
            for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
                if (lvl_count[l] != 0) begin
                    found = 1'b1;
                    lvl   = l;
                end
            end
            if (found) begin
                e       = lvl_entries[lvl][lvl_head[lvl]];
                r.id    = e.id;
                r.level = lvl[mlfs_pkg::RLEVEL_W-1:0];
                rem     = (e.remain != '0) ? e.remain - 1'b1 : '0;
                sl      = (lvl_slice[lvl] != '0) ? lvl_slice[lvl] - 1'b1 : '0;
                if (sl == '0) sl = slice_length(lvl);
                if (rem == '0) begin
                    dequeue_head(lvl);
                    held_tasks--;
                    r.status = mlfs_pkg::ST_FINISHED;
                end else if (lvl_slice[lvl] <= 16'd1) begin
                    // Slice used up: demote, or rotate within the last level.
                    dest = (lvl + 1 < NUM_LEVELS) ? lvl + 1 : lvl;
                    dequeue_head(lvl);
                    enqueue_task(dest, e.id, rem);
                    r.status = (dest != lvl) ? mlfs_pkg::ST_MOVED_DOWN : mlfs_pkg::ST_RAN;
                end else begin
                    lvl_entries[lvl][lvl_head[lvl]].remain = rem;
                    r.status = mlfs_pkg::ST_RAN;
                end
                lvl_slice[lvl] = sl;
                r.remain       = rem;
            end
        end
        return r;
    endfunction

    task automatic add_request(logic op, logic [ID_W-1:0] id, logic [TIME_W-1:0] svc);
        request_t r;
        r.op  = op;
        r.id  = id;
        r.svc = svc;
        request_queue.push_back(r);
    endtask

    // Mostly short jobs so that tasks finish and levels keep moving.
    function automatic logic [TIME_W-1:0] random_service(bit wide);
        int pick;
        pick = $urandom_range(0, 99);
        if (wide && pick < 3) return 16'($urandom_range(0, 65535));
        if (pick < 5) return '0;
        if (pick < 75) return 16'($urandom_range(1, 3));
        if (pick < 95) return 16'($urandom_range(4, 12));
        return 16'($urandom_range(13, 80));
    endfunction

    task automatic add_tick();
        add_request(mlfs_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
    endtask

    task automatic write_reg(int idx, logic [mlfs_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx[mlfs_pkg::CFG_IDX_W-1:0];
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx < NUM_QREGS) q_quantum[idx] = value;
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_valid || outcome_queue.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One phase of random traffic under the current quanta.
    task automatic run_phase(int n_items, int tick_pct, bit wide);
        int added;
        int n_arrive;
        int n_ticks;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // Loose mix of arrivals and ticks.
                n_arrive = $urandom_range(1, 10);
                repeat (n_arrive) begin
                    if ($urandom_range(0, 99) < tick_pct) add_tick();
                    else add_request(mlfs_pkg::OP_ARRIVE, 8'($urandom_range(0, 255)),
                                     random_service(wide));
                end
                added += n_arrive;
            end else begin
                // A batch of arrivals, then a run of ticks to work some of it off.
                n_arrive = $urandom_range(1, 5);
                n_ticks  = $urandom_range(0, 2 * n_arrive * tick_pct / (100 - tick_pct));
                repeat (n_arrive) add_request(mlfs_pkg::OP_ARRIVE, 8'($urandom_range(0, 255)),
                                              random_service(wide));
                repeat (n_ticks) add_tick();
                added += n_arrive + n_ticks;
            end
        end
        // Halfway through, the sender waits until the block has caught up completely.
        while (request_queue.size() > added / 2) @(negedge aclk);
        hold_sender = 1'b1;
        while (s_valid || outcome_queue.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
        hold_sender = 1'b0;
        wait_idle();
    endtask

    // Main sequence: reset, directed items, then random phases under several quanta.
    initial begin
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Idle tick with the ignored fields at all ones.
        add_request(mlfs_pkg::OP_TICK, 8'hFF, 16'hFFFF);
        // A task with zero service time finishes at its first tick.
        add_request(mlfs_pkg::OP_ARRIVE, 8'h00, 16'h0000);
        add_request(mlfs_pkg::OP_TICK, 8'h00, 16'h0000);
        // Two tasks: the first runs, uses up its slice and moves down; the second finishes.
        add_request(mlfs_pkg::OP_ARRIVE, 8'hC3, 16'd3);
        add_request(mlfs_pkg::OP_ARRIVE, 8'h3C, 16'd1);
        repeat (4) add_tick();
        // Fill the scheduler, then an arrival that must be turned away.
        for (int i = 0; i < QUEUE_DEPTH; i++)
            add_request(mlfs_pkg::OP_ARRIVE, (i == 0) ? 8'hFF : 8'(i * 17),
                        random_service(1'b0));
        add_request(mlfs_pkg::OP_ARRIVE, 8'hFF, 16'hFFFF);
        run_phase(250, 70, 1'b0);

        // Shortest slices everywhere.
        for (int i = 0; i < NUM_QREGS; i++) write_reg(i, 16'd1);
        run_phase(260, 70, 1'b0);

        // Zero quanta behave as one; writes to unused indexes are ignored.
        write_reg(0, 16'd0);
        write_reg(1, 16'd3);
        write_reg(2, 16'd0);
        write_reg(3, 16'd2);
        for (int i = NUM_QREGS; i < NUM_CFG_SLOTS; i++)
            write_reg(i, 16'($urandom_range(0, 65535)));
        run_phase(260, 55, 1'b0);

        for (int i = 0; i < NUM_QREGS; i++) write_reg(i, 16'($urandom_range(1, 6)));
        run_phase(260, 75, 1'b0);

        for (int i = 0; i < NUM_QREGS; i++) write_reg(i, 16'($urandom_range(1, 4)));
        run_phase(260, 85, 1'b0);

        // Longest slices last, since a long slice holds a level for many ticks afterwards.
        for (int i = 0; i < NUM_QREGS; i++) write_reg(i, 16'hFFFF);
        run_phase(260, 70, 1'b1);

        if (outcome_queue.size() != 0) begin
            $display("%0t: %0d expected outcomes never arrived", $time, outcome_queue.size());
            n_errors++;
        end
        $display("Covered %0d items under six quantum settings: %0d accepted, %0d rejected,",
                 n_accepted, status_seen[mlfs_pkg::ST_ACCEPTED],
                 status_seen[mlfs_pkg::ST_REJECTED]);
        $display("  %0d idle ticks, %0d ran, %0d finished, %0d moved down; %0d errors.",
                 status_seen[mlfs_pkg::ST_IDLE_TICK], status_seen[mlfs_pkg::ST_RAN],
                 status_seen[mlfs_pkg::ST_FINISHED], status_seen[mlfs_pkg::ST_MOVED_DOWN],
                 n_errors);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Sender: presents queued items in bursts and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted = scheduler_step(s_op, s_task_id, s_service_time);
                outcome_queue.push_back(predicted);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_queue.size() != 0 && !hold_sender) begin
                    next_req = request_queue.pop_front();
                    s_valid        <= 1'b1;
                    s_op           <= next_req.op;
                    s_task_id      <= next_req.id;
                    s_service_time <= next_req.svc;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                  : $urandom_range(1, 8);
                    burst_left--;
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) gap_left = 0;
                        else if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(10, 25);
                        else gap_left = $urandom_range(1, 4);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted outcome and stalls in changing patterns.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                status_seen[m_status]++;
                if (outcome_queue.size() == 0) begin
                    $display("%0t: outcome with none expected, actual status %0d task %0d",
                             $time, m_status, m_run_task_id);
                    n_errors++;
                end else begin
                    want = outcome_queue.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_status);
                        n_errors++;
                    end
                    if (m_run_task_id !== want.id) begin
                        $display("%0t: task id mismatch, expected %0d, actual %0d",
                                 $time, want.id, m_run_task_id);
                        n_errors++;
                    end
                    if (m_run_level !== want.level) begin
                        $display("%0t: level mismatch, expected %0d, actual %0d",
                                 $time, want.level, m_run_level);
                        n_errors++;
                    end
                    if (m_remaining_after !== want.remain) begin
                        $display("%0t: remaining time mismatch, expected %0d, actual %0d",
                                 $time, want.remain, m_remaining_after);
                        n_errors++;
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                RX_ALWAYS:   m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_ready <= (rx_left % 4 == 0);
                default:     m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog on the length of the run.
    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
